// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a property, sampled at the rising clock edge,
// switched off while reset is held low.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition post must hold in the cycle after the condition pre.
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
  `SPQ_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// File: hdl/spq_pkg.sv
package spq_pkg;

  // Default number of queue slots.
  localparam int SPQ_CAPACITY = 16;
  // Width of a stored value and of a priority.
  localparam int DATA_W = 32;
  // One stored entry holds the priority above the value.
  localparam int ENTRY_W = 2 * DATA_W;

  // Result codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Operation codes carried on the input tuser.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_HEAD,
    S_DEL_RD,
    S_DEL_CAP,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  // Slot index pointer operations.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TAIL,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // Write address relative to the slot index pointer.
  typedef enum logic [1:0] {
    WA_IDX,
    WA_NEXT,
    WA_PREV
  } wr_addr_sel_t;

  // Write data source: the new item or the entry just read.
  typedef enum logic {
    WS_ITEM,
    WS_SHIFT
  } wr_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_item;
    idx_op_t      idx_op;
    logic         rd_en;
    logic         wr_en;
    wr_addr_sel_t wr_addr_sel;
    wr_src_t      wr_src;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         capture_front;
    logic         status_we;
    status_t      status_code;
    logic         out_load;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic prio_gt;
    logic idx_zero;
    logic idx_last;
    logic out_free;
  } spq_stat_t;

endpackage

// File: hdl/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/spq_datapath.sv
module spq_datapath import spq_pkg::*; #(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DATA_W-1:0]   in_value,
  input  logic [DATA_W-1:0]   in_prio,
  input  spq_cmd_t            cmd,
  output spq_stat_t           stat,
  input  logic                out_tready,
  output logic                out_tvalid,
  output status_t             out_status,
  output logic [DATA_W-1:0]   out_value,
  output logic [DATA_W-1:0]   out_prio
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] item_value_r;
  logic signed [DATA_W-1:0] item_prio_r;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [ENTRY_W-1:0]       front_r;
  status_t                  res_status_r;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r;
  logic [DATA_W-1:0]        out_value_r;
  logic [DATA_W-1:0]        out_prio_r;

  logic [AW-1:0]            wr_addr;
  logic [ENTRY_W-1:0]       wr_data;
  logic [ENTRY_W-1:0]       rd_data;
  logic signed [DATA_W-1:0] rd_prio;

  // Slot storage: priority in the upper half, value in the lower half.
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Write address and data selection.
  always_comb begin
    case (cmd.wr_addr_sel)
      WA_IDX:  wr_addr = idx_r;
      WA_NEXT: wr_addr = idx_r + AW'(1);
      WA_PREV: wr_addr = idx_r - AW'(1);
      default: wr_addr = idx_r;
    endcase
    if (cmd.wr_src == WS_ITEM) begin
      wr_data = {item_prio_r, item_value_r};
    end else begin
      wr_data = rd_data;
    end
  end

  // Slot index pointer.
  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD: idx_nxt = idx_r;
      IDX_ZERO: idx_nxt = '0;
      IDX_TAIL: idx_nxt = count_r[AW-1:0] - AW'(1);
      IDX_INC:  idx_nxt = idx_r + AW'(1);
      IDX_DEC:  idx_nxt = idx_r - AW'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  // Fill count of the occupied prefix.
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // The output register empties on a taken beat and fills on a load.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_item) begin
      item_value_r <= in_value;
      item_prio_r  <= in_prio;
    end
    if (cmd.capture_front) begin
      front_r <= rd_data;
    end
    if (cmd.status_we) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      if (res_status_r == ST_DELETED) begin
        out_value_r <= front_r[DATA_W-1:0];
        out_prio_r  <= front_r[ENTRY_W-1:DATA_W];
      end else begin
        out_value_r <= '0;
        out_prio_r  <= '0;
      end
    end
  end

  // Status toward the controller.
  assign rd_prio        = rd_data[ENTRY_W-1:DATA_W];
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.prio_gt   = (rd_prio > item_prio_r);
  assign stat.idx_zero  = (idx_r == '0);
  assign stat.idx_last  = ((CW'(idx_r) + CW'(1)) == count_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_prio   = out_prio_r;

endmodule

// File: hdl/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_func,
  output logic      in_tready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_func == FUNC_INSERT) begin
            if (stat.full) begin
              state_nxt = S_DONE;
            end else if (stat.empty) begin
              state_nxt = S_INS_HEAD;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            if (stat.empty) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_DEL_RD;
            end
          end
        end
      end
      S_INS_RD: state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (!stat.prio_gt) begin
          state_nxt = S_DONE;
        end else if (stat.idx_zero) begin
          state_nxt = S_INS_HEAD;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_HEAD: state_nxt = S_DONE;
      S_DEL_RD:   state_nxt = S_DEL_CAP;
      S_DEL_CAP: begin
        state_nxt = stat.idx_last ? S_DONE : S_SH_RD;
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        state_nxt = stat.idx_last ? S_DONE : S_SH_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands for each state.
  always_comb begin
    cmd             = '0;
    cmd.idx_op      = IDX_HOLD;
    cmd.wr_addr_sel = WA_IDX;
    cmd.wr_src      = WS_ITEM;
    cmd.status_code = ST_INSERTED;
    in_tready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
        if (in_tvalid) begin
          if (in_func == FUNC_INSERT) begin
            if (stat.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_OVERFLOW;
            end else if (stat.empty) begin
              cmd.idx_op = IDX_ZERO;
            end else begin
              cmd.idx_op = IDX_TAIL;
            end
          end else begin
            if (stat.empty) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = ST_UNDERFLOW;
            end else begin
              cmd.idx_op = IDX_ZERO;
            end
          end
        end
      end
      S_INS_RD: cmd.rd_en = 1'b1;
      S_INS_CMP: begin
        // Move a larger entry up one slot, or drop the new item in behind
        // the first entry that is not larger.
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_NEXT;
        if (stat.prio_gt) begin
          cmd.wr_src = WS_SHIFT;
          if (!stat.idx_zero) begin
            cmd.idx_op = IDX_DEC;
          end
        end else begin
          cmd.wr_src      = WS_ITEM;
          cmd.cnt_inc     = 1'b1;
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_INSERTED;
        end
      end
      S_INS_HEAD: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_IDX;
        cmd.wr_src      = WS_ITEM;
        cmd.cnt_inc     = 1'b1;
        cmd.status_we   = 1'b1;
        cmd.status_code = ST_INSERTED;
      end
      S_DEL_RD: cmd.rd_en = 1'b1;
      S_DEL_CAP: begin
        cmd.capture_front = 1'b1;
        if (stat.idx_last) begin
          cmd.cnt_dec     = 1'b1;
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_DELETED;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_SH_RD: cmd.rd_en = 1'b1;
      S_SH_WR: begin
        // Move each entry down one slot toward the front.
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_PREV;
        cmd.wr_src      = WS_SHIFT;
        if (stat.idx_last) begin
          cmd.cnt_dec     = 1'b1;
          cmd.status_we   = 1'b1;
          cmd.status_code = ST_DELETED;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_DONE: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue with a fixed number of slots (CAPACITY).
// Input channel: each beat is one operation. in_tuser[0] selects insert (0)
// or delete of the front entry (1); in_tdata carries the value and the
// priority of an insert and is ignored on a delete. Smaller priorities leave
// first; equal priorities leave in arrival order.
// Output channel: exactly one beat per operation, in order. out_tuser holds
// the status: inserted, deleted, underflow (delete on an empty queue) or
// overflow (insert on a full queue, dropped). out_tdata holds the removed
// value and priority on a delete and zeros otherwise.
// Sequencing: entries sit in a single-port-read RAM and are moved one slot at
// a time by a controller. An insert moves each larger entry up one slot from
// the tail and writes the new item behind the first entry that is not larger;
// a delete reads the front entry and moves every entry behind it down one slot.
// Overflow and underflow go straight to the result. One operation is in work at a time.
// The output is registered: a new input beat is taken while an earlier
// result still waits, and a stalled receiver holds the block in its final
// step until the result register frees.
// Reset (rst_n low, synchronous) empties the queue through the fill count;
// no clearing pass is needed and the block is ready in the next cycle.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ENTRY_W-1:0] in_tdata,   // item_value [31:0], item_priority [63:32]
  input  logic [0:0]         in_tuser,   // func [0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ENTRY_W-1:0] out_tdata,  // removed_value [31:0], removed_priority [63:32]
  output logic [1:0]         out_tuser   // status [1:0]
);

  spq_cmd_t  cmd;
  spq_stat_t stat;
  status_t   out_status;

  // Sequencer for insert scans and delete shifts.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser[0]),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slot storage, pointers and result register.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[DATA_W-1:0]),
    .in_prio    (in_tdata[ENTRY_W-1:DATA_W]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (out_status),
    .out_value  (out_tdata[DATA_W-1:0]),
    .out_prio   (out_tdata[ENTRY_W-1:DATA_W])
  );

  assign out_tuser = out_status;

endmodule

// File: hdl/spq_checker.sv
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = SPQ_CAPACITY
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [ENTRY_W-1:0] out_tdata,
  input logic [1:0]         out_tuser
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] occ_r, occ_nxt;
  logic          out_beat;

  // Occupancy as seen from the delivered results.
  assign out_beat = out_tvalid && out_tready;

  always_comb begin
    occ_nxt = occ_r;
    if (out_beat && (out_tuser == ST_INSERTED)) begin
      occ_nxt = occ_r + CW'(1);
    end else if (out_beat && (out_tuser == ST_DELETED)) begin
      occ_nxt = occ_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A stalled result holds its payload.
  `SPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only a delete returns nonzero data.
  `SPQ_ASSERT(a_zero_data, out_tvalid && (out_tuser != ST_DELETED) |-> (out_tdata == '0), "nonzero data on a non-delete result")

  // Underflow only on an empty queue, and a delete only on a nonempty one.
  `SPQ_ASSERT(a_underflow, out_tvalid && (out_tuser == ST_UNDERFLOW) |-> (occ_r == '0), "underflow reported on a nonempty queue")
  `SPQ_ASSERT(a_delete_occ, out_tvalid && (out_tuser == ST_DELETED) |-> (occ_r != '0), "delete reported on an empty queue")

  // Overflow only when full.
  `SPQ_ASSERT(a_overflow, out_tvalid && (out_tuser == ST_OVERFLOW) |-> (occ_r == CW'(CAPACITY)), "overflow status does not match fill level")

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

import spq_pkg::*;

// Tracks the queue contents as the block should hold them and compares every
// result beat against the oldest outcome still owed.
class queue_scoreboard;

  typedef struct {
    logic [DATA_W-1:0] value;
    int                prio;
  } slot_entry_t;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } outcome_t;

  slot_entry_t shadow_slots[$];
  outcome_t    expected_outcomes[$];
  int unsigned failures = 0;

  // Applies one accepted operation to the shadow queue and records its outcome.
  function void note_operation(logic func, logic [DATA_W-1:0] value,
                               logic [DATA_W-1:0] prio);
    outcome_t    result;
    slot_entry_t fresh;
    int          pos;
    result.status = ST_INSERTED;
    result.value  = '0;
    result.prio   = '0;
    if (func == FUNC_INSERT) begin
      if (shadow_slots.size() >= SPQ_CAPACITY) begin
        result.status = ST_OVERFLOW;
      end else begin
        // The new entry goes behind every entry of equal or smaller priority.
        pos = 0;
        while (pos < shadow_slots.size() && shadow_slots[pos].prio <= int'(prio))
          pos++;
        fresh.value = value;
        fresh.prio  = int'(prio);
        shadow_slots.insert(pos, fresh);
      end
    end else begin
      if (shadow_slots.size() == 0) begin
        result.status = ST_UNDERFLOW;
      end else begin
        fresh = shadow_slots.pop_front();
        result.status = ST_DELETED;
        result.value  = fresh.value;
        result.prio   = fresh.prio;
      end
    end
    expected_outcomes.push_back(result);
  endfunction

  // Compares one result beat field by field with the oldest expected outcome.
  function void check_outcome(logic [ENTRY_W-1:0] tdata, logic [1:0] tuser);
    outcome_t want;
    if (expected_outcomes.size() == 0) begin
      $display("%0t: unexpected result beat: status %0d data %h", $time, tuser, tdata);
      failures++;
      return;
    end
    want = expected_outcomes.pop_front();
    if (tuser !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
      failures++;
    end
    if (tdata[DATA_W-1:0] !== want.value) begin
      $display("%0t: removed value expected %h actual %h", $time, want.value,
               tdata[DATA_W-1:0]);
      failures++;
    end
    if (tdata[ENTRY_W-1:DATA_W] !== want.prio) begin
      $display("%0t: removed priority expected %h actual %h", $time, want.prio,
               tdata[ENTRY_W-1:DATA_W]);
      failures++;
    end
  endfunction

  function int pending();
    return expected_outcomes.size();
  endfunction

endclass

module testbench;

  localparam int TOTAL_OPS   = 1950;
  localparam int HOLD_AT     = 600;
  localparam int BURST_FROM  = 1200;
  localparam int BURST_TO    = 1450;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 2 * SPQ_CAPACITY + 10;
  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [ENTRY_W-1:0] in_tdata;
  logic [0:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [ENTRY_W-1:0] out_tdata;
  logic [1:0]         out_tuser;

  queue_scoreboard sb = new();
  int unsigned     ops_sent = 0;
  int unsigned     cycles = 0;
  bit              hold_req = 1'b0;
  bit              no_idle = 1'b0;

  sorted_priority_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_unit: mismatch");
      $finish;
    end
  end

  // Result beats are checked at the edge where they are taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_outcome(out_tdata, out_tuser);
  end

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // Offers one operation beat and waits until the block takes it.
  task automatic send_op(logic func, logic [DATA_W-1:0] value, logic [DATA_W-1:0] prio);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, value};
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_operation(func, value, prio);
    ops_sent++;
  endtask

  // Priorities cluster in a narrow band so that ties are common.
  function automatic logic [DATA_W-1:0] pick_priority();
    logic [DATA_W-1:0] p;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: p = $urandom_range(7);
      6:                p = -int'($urandom_range(8));
      7, 8:             p = $urandom;
      default:          p = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
    return p;
  endfunction

  // Phases favour inserts, deletes or neither; the queue swings from full to empty.
  task automatic random_until(int unsigned target);
    int unsigned phase_len;
    int unsigned insert_pct;
    while (ops_sent < target) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      for (int k = 0; k < phase_len && ops_sent < target; k++) begin
        if ($urandom_range(99) < insert_pct)
          send_op(FUNC_INSERT, $urandom, pick_priority());
        else
          send_op(FUNC_DELETE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FUNC_INSERT;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty delete, extreme fields, ties at zero and at the top.
    send_op(FUNC_DELETE, 32'h0, 32'h0);
    send_op(FUNC_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_op(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h0000_0001, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FUNC_INSERT, 32'h0000_0002, 32'h0000_0000);
    send_op(FUNC_INSERT, 32'h0000_0003, 32'h7FFF_FFFF);
    repeat (7) send_op(FUNC_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(FUNC_DELETE, 32'h0, 32'h0);

    // Random: one long receiver hold-off, then a stretch without any idling.
    random_until(HOLD_AT);
    hold_req = 1'b1;
    random_until(BURST_FROM);
    no_idle = 1'b1;
    random_until(BURST_TO);
    no_idle = 1'b0;
    random_until(TOTAL_OPS);
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.failures == 0)
      $display("sorted_priority_queue_unit: match");
    else
      $display("sorted_priority_queue_unit: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue_unit.sv
hdl/spq_checker.sv
test/testbench.sv
